// ===== design/stp_pkg.sv =====
// Shared constants and types for the stepper step pulse generator.
`timescale 1ns / 1ps
`default_nettype none
package stp_pkg;

	localparam int unsigned FRAC_BITS_DEF = 8;
	localparam int unsigned VEL_W         = 16;
	localparam int unsigned TIME_W        = 32;
	localparam int unsigned CFG_IDX_W     = 2;
	localparam int unsigned CFG_DATA_W    = 32;
	localparam int unsigned IN_TDATA_W    = 48;
	localparam int unsigned OUT_TDATA_W   = 40;

	localparam logic [31:0] SCALE_RST = 32'd1000000;
	localparam logic [31:0] MIN_RST   = 32'd200;
	localparam logic [31:0] MAX_RST   = 32'd100000;

	localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] POS_MIN = 32'h8000_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SCALE = 2'd0,
		CFG_MIN   = 2'd1,
		CFG_MAX   = 2'd2
	} cfg_idx_t;

	typedef enum logic {
		OP_TIME = 1'b0,
		OP_VEL  = 1'b1
	} opcode_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage
`default_nettype wire

// ===== design/stp_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module stp_div #(
	parameter int unsigned DVD_W = 32 + stp_pkg::FRAC_BITS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [DVD_W-1:0]          dividend,
	input  wire logic [stp_pkg::VEL_W-1:0] divisor,
	output stp_pkg::div_stat_t             stat,
	output logic [DVD_W-1:0]               quotient
);
	import stp_pkg::*;

	localparam int unsigned CNT_W = $clog2(DVD_W);

	logic [DVD_W-1:0] dvd_q;
	logic [VEL_W-1:0] rem_q;
	logic [VEL_W-1:0] dsr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [VEL_W:0] rem_sh;
	logic [VEL_W:0] rem_sub;
	logic           ge;

	assign rem_sh  = {rem_q, dvd_q[DVD_W-1]};
	assign ge      = rem_sh >= {1'b0, dsr_q};
	assign rem_sub = rem_sh - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			dvd_q  <= '0;
			rem_q  <= '0;
			dsr_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W - 1);
				dvd_q  <= dividend;
				rem_q  <= '0;
				dsr_q  <= divisor;
			end else if (busy_q) begin
				rem_q <= ge ? rem_sub[VEL_W-1:0] : rem_sh[VEL_W-1:0];
				dvd_q <= {dvd_q[DVD_W-2:0], ge};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = dvd_q;

endmodule
`default_nettype wire

// ===== design/stepper_step_pulse_generator_unit.sv =====
// Top level of the stepper step pulse generator.
//
// Input stream (s_*): tuser carries the opcode, 0 time sample, 1 velocity update.
// A velocity update sets direction and computes the step interval
// scale_factor * 2^FRAC_BITS / |velocity| with a bit-serial divider,
// clamped to min_interval and stopped above max_interval or at zero velocity.
// A time sample emits a step when the time since the next-step mark
// reaches the interval and updates the saturating position.
// Output stream (m_*): one result per input item.
// Steps per item: a velocity update passes S_DIV, where the divider
// produces one quotient bit per cycle, then S_CLAMP and S_FIN; a time
// sample that steps passes S_TCHK, S_TDIFF, S_TLAG and S_FIN, one that does
// not step S_TCHK and S_FIN; zero velocity, or a time sample while stopped,
// goes straight to S_FIN. The result is valid from the same cycle in which the next item can be accepted.
// One item is in work at a time; the next is accepted once the result has
// moved to the output register, even while that register waits on m_tready.
// While m_tready stays low a second result waits in work and s_tready is low.
// Configuration writes (cfg_*) are always ready and take effect at once.
// Reset restores the default registers, stops the axis and clears position.
`timescale 1ns / 1ps
`default_nettype none
module stepper_step_pulse_generator_unit #(
	parameter int unsigned FRAC_BITS = stp_pkg::FRAC_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// [15:0] velocity, [47:16] now_us
	input  wire logic [stp_pkg::IN_TDATA_W-1:0]  s_tdata,
	// [0] opcode
	input  wire logic                            s_tuser,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// [0] step_pulse, [1] direction, [33:2] step_count, [34] running, zero fill
	output logic [stp_pkg::OUT_TDATA_W-1:0]      m_tdata,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [stp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [stp_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import stp_pkg::*;

	localparam int unsigned DVD_W = 32 + FRAC_BITS;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_CLAMP,
		S_TCHK,
		S_TDIFF,
		S_TLAG,
		S_FIN
	} state_t;

	state_t state_q;

	logic [31:0] scale_q;
	logic [31:0] min_q;
	logic [31:0] max_q;

	logic        dir_q;
	logic        fwd_q;
	logic [31:0] intv_q;
	logic [31:0] mark_q;
	logic [31:0] pos_q;

	logic [TIME_W-1:0] now_q;
	logic [31:0]       diff_q;
	logic [DVD_W-1:0]  qc_q;
	logic              pulse_q;

	logic        m_tvalid_q;
	logic        o_pulse_q;
	logic        o_dir_q;
	logic [31:0] o_pos_q;
	logic        o_run_q;

	logic              accept;
	logic [VEL_W-1:0]  vel;
	logic [VEL_W-1:0]  vel_mag;
	logic [TIME_W-1:0] now_in;
	logic              div_start;
	div_stat_t         div_stat;
	logic [DVD_W-1:0]  quot;
	logic [DVD_W-1:0]  dividend;

	assign s_tready  = (state_q == S_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign vel       = s_tdata[VEL_W-1:0];
	assign now_in    = s_tdata[VEL_W +: TIME_W];
	assign vel_mag   = vel[VEL_W-1] ? (~vel + 1'b1) : vel;
	assign div_start = accept && (s_tuser == OP_VEL) && (vel != '0);
	assign dividend  = DVD_W'(scale_q) << FRAC_BITS;
	assign cfg_ready = 1'b1;

	stp_div #(
		.DVD_W(DVD_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (vel_mag),
		.stat     (div_stat),
		.quotient (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RST;
			min_q   <= MIN_RST;
			max_q   <= MAX_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_SCALE: scale_q <= cfg_data;
				CFG_MIN:   min_q   <= cfg_data;
				CFG_MAX:   max_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			dir_q      <= 1'b0;
			fwd_q      <= 1'b0;
			intv_q     <= '0;
			mark_q     <= '0;
			pos_q      <= '0;
			now_q      <= '0;
			diff_q     <= '0;
			qc_q       <= '0;
			pulse_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
			o_pulse_q  <= 1'b0;
			o_dir_q    <= 1'b0;
			o_pos_q    <= '0;
			o_run_q    <= 1'b0;
		end else begin
			// in S_FIN the output register is either reloaded or still waiting
			if (m_tvalid_q && m_tready && (state_q != S_FIN)) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						pulse_q <= 1'b0;
						if (s_tuser == OP_VEL) begin
							fwd_q <= !vel[VEL_W-1] && (vel != '0);
							if (vel == '0) begin
								intv_q  <= '0;
								state_q <= S_FIN;
							end else begin
								dir_q   <= !vel[VEL_W-1];
								state_q <= S_DIV;
							end
						end else if (intv_q == '0) begin
							state_q <= S_FIN;
						end else begin
							now_q   <= now_in;
							diff_q  <= now_in - mark_q;
							state_q <= S_TCHK;
						end
					end
				end
				S_DIV: begin
					if (div_stat.done) begin
						qc_q    <= (quot < DVD_W'(min_q)) ? DVD_W'(min_q) : quot;
						state_q <= S_CLAMP;
					end
				end
				S_CLAMP: begin
					if (qc_q > DVD_W'(max_q) || qc_q == '0) begin
						intv_q <= '0;
					end else begin
						intv_q <= qc_q[31:0];
					end
					state_q <= S_FIN;
				end
				S_TCHK: begin
					if (diff_q < intv_q) begin
						state_q <= S_FIN;
					end else begin
						mark_q  <= mark_q + intv_q;
						state_q <= S_TDIFF;
					end
				end
				S_TDIFF: begin
					diff_q  <= now_q - mark_q;
					state_q <= S_TLAG;
				end
				S_TLAG: begin
					if ({1'b0, diff_q} > {intv_q, 1'b0}) begin
						mark_q <= now_q + intv_q;
					end
					if (fwd_q) begin
						if (pos_q != POS_MAX) pos_q <= pos_q + 32'd1;
					end else begin
						if (pos_q != POS_MIN) pos_q <= pos_q - 32'd1;
					end
					pulse_q <= 1'b1;
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						o_pulse_q  <= pulse_q;
						o_dir_q    <= dir_q;
						o_pos_q    <= pos_q;
						o_run_q    <= (intv_q != '0);
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {(OUT_TDATA_W - 35)'(0), o_run_q, o_pos_q, o_dir_q, o_pulse_q};

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("input taken while an item is in work");

	a_div_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (div_stat.busy || div_stat.done))
		else $error("waiting on an idle divider");

	a_pulse_running: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && o_pulse_q) |-> o_run_q)
		else $error("step emitted while stopped");

	a_pos_step: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_q != $past(pos_q)) |->
			(pos_q == $past(pos_q) + 32'd1 || pos_q == $past(pos_q) - 32'd1))
		else $error("position moved by more than one step");

endmodule
`default_nettype wire

// ===== sim/tb_stepper_step_pulse_generator_unit.sv =====
// Testbench for the stepper step pulse generator: directed and random streams checked against a predictor.
`timescale 1ns / 1ps
module tb_stepper_step_pulse_generator_unit;
	import stp_pkg::*;

	localparam int unsigned FRAC        = FRAC_BITS_DEF;
	localparam int unsigned CYCLE_LIMIT = 1_500_000;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned END_CYCLES  = 60;

	typedef enum int {
		STALL_RX_HEAVY,
		STALL_TX_HEAVY,
		STALL_NONE
	} stall_mode_t;

	typedef struct {
		opcode_t     op;
		logic [15:0] vel;
		logic [31:0] now_us;
	} motion_item_t;

	typedef struct {
		logic        pulse;
		logic        dir;
		logic [31:0] count;
		logic        running;
	} axis_status_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_TDATA_W-1:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	stepper_step_pulse_generator_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	motion_item_t cmd_q[$];
	axis_status_t status_q[$];
	motion_item_t drive_cmd;
	int unsigned items_queued = 0;
	int unsigned items_accepted = 0;
	int unsigned err_count = 0;
	int unsigned cycle_count = 0;
	int unsigned send_idle_pct = 28;
	int unsigned recv_idle_pct = 85;
	int unsigned hold_req = 0;
	int unsigned hold_seen = 0;
	int unsigned hold_left = 0;
	logic [31:0] sample_clock = '0;

	// predictor copy of registers and axis state
	logic [31:0] cfg_scale = SCALE_RST;
	logic [31:0] cfg_min = MIN_RST;
	logic [31:0] cfg_max = MAX_RST;
	logic        axis_dir = 1'b0;
	logic        axis_fwd = 1'b0;
	logic [31:0] axis_interval = '0;
	logic [31:0] axis_mark = '0;
	logic [31:0] axis_pos = '0;

	function automatic axis_status_t advance_axis(input motion_item_t it);
		axis_status_t r;
		logic [63:0] mag;
		logic [63:0] quo;
		logic [31:0] since;
		r.pulse = 1'b0;
		if (it.op == OP_VEL) begin
			mag = it.vel[15] ? 64'(17'h10000 - {1'b0, it.vel}) : 64'(it.vel);
			axis_fwd = !it.vel[15] && it.vel != 16'd0;
			if (it.vel == 16'd0) begin
				axis_interval = '0;
			end else begin
				axis_dir = !it.vel[15];
				quo = ({32'd0, cfg_scale} << FRAC) / mag;
				if (quo < {32'd0, cfg_min})
					quo = {32'd0, cfg_min};
				if (quo > {32'd0, cfg_max} || quo == 64'd0)
					axis_interval = '0;
				else
					axis_interval = quo[31:0];
			end
		end else if (axis_interval != 32'd0) begin
			since = it.now_us - axis_mark;
			if (since >= axis_interval) begin
				r.pulse = 1'b1;
				axis_mark = axis_mark + axis_interval;
				since = it.now_us - axis_mark;
				// lag test at 33 bits
				if ({1'b0, since} > {axis_interval, 1'b0})
					axis_mark = it.now_us + axis_interval;
				if (axis_fwd) begin
					if (axis_pos != POS_MAX)
						axis_pos = axis_pos + 32'd1;
				end else if (axis_pos != POS_MIN) begin
					axis_pos = axis_pos - 32'd1;
				end
			end
		end
		r.dir = axis_dir;
		r.count = axis_pos;
		r.running = axis_interval != 32'd0;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (cmd_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
				drive_cmd = cmd_q.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {drive_cmd.now_us, drive_cmd.vel};
				s_tuser <= drive_cmd.op;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_seen != hold_req) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= $urandom_range(99, 0) >= recv_idle_pct;
		end
	end

	always @(posedge clk) begin
		axis_status_t want;
		motion_item_t took;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (status_q.size() == 0) begin
					$error("result transfer with no expectation: tdata %h", m_tdata);
					err_count++;
				end else begin
					want = status_q.pop_front();
					if (m_tdata[0] !== want.pulse) begin
						$error("step_pulse mismatch: expected %0d, actual %0d",
							want.pulse, m_tdata[0]);
						err_count++;
					end
					if (m_tdata[1] !== want.dir) begin
						$error("direction mismatch: expected %0d, actual %0d",
							want.dir, m_tdata[1]);
						err_count++;
					end
					if (m_tdata[33:2] !== want.count) begin
						$error("step_count mismatch: expected %0d, actual %0d",
							$signed(want.count), $signed(m_tdata[33:2]));
						err_count++;
					end
					if (m_tdata[34] !== want.running) begin
						$error("running mismatch: expected %0d, actual %0d",
							want.running, m_tdata[34]);
						err_count++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				took.op = opcode_t'(s_tuser);
				took.vel = s_tdata[15:0];
				took.now_us = s_tdata[47:16];
				status_q.push_back(advance_axis(took));
				items_accepted++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic queue_item(input opcode_t op, input logic [15:0] vel,
		input logic [31:0] now_us);
		motion_item_t it;
		it.op = op;
		it.vel = vel;
		it.now_us = now_us;
		cmd_q.push_back(it);
		items_queued++;
	endtask

	task automatic wait_settled();
		while (items_accepted != items_queued || status_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_SCALE: cfg_scale = val;
			CFG_MIN:   cfg_min = val;
			CFG_MAX:   cfg_max = val;
			default:   ;
		endcase
	endtask

	task automatic configure_axis(input logic [31:0] scale, input logic [31:0] lo_iv,
		input logic [31:0] hi_iv, input stall_mode_t mode);
		wait_settled();
		write_reg(CFG_SCALE, scale);
		write_reg(CFG_MIN, lo_iv);
		write_reg(CFG_MAX, hi_iv);
		case (mode)
			STALL_RX_HEAVY: begin
				send_idle_pct <= 28;
				recv_idle_pct <= 85;
			end
			STALL_TX_HEAVY: begin
				send_idle_pct <= 85;
				recv_idle_pct <= 28;
			end
			default: begin
				send_idle_pct <= 0;
				recv_idle_pct <= 0;
			end
		endcase
	endtask

	// mostly in-range velocities and time advancing near the interval scale
	task automatic queue_random(input int n, input logic [31:0] span, input int vlo,
		input int vhi);
		int k;
		int mag;
		logic [15:0] vel;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99, 0) < 12) begin
				k = $urandom_range(9, 0);
				if (k == 0) begin
					vel = 16'd0;
				end else if (k == 1) begin
					vel = 16'($urandom);
				end else begin
					mag = $urandom_range(vhi, vlo);
					vel = $urandom_range(1, 0) ? 16'(-mag) : 16'(mag);
				end
				queue_item(OP_VEL, vel, $urandom);
			end else begin
				k = $urandom_range(99, 0);
				if (k < 85)
					sample_clock = sample_clock + $urandom_range(span, 0);
				else if (k < 95)
					sample_clock = sample_clock + span + $urandom_range(3 * span, 0);
				else
					sample_clock = $urandom;
				queue_item(OP_TIME, 16'($urandom), sample_clock);
			end
		end
	endtask

	initial begin
		logic [31:0] m;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// reset registers: stopped samples, zero velocity, exact step, lag, sign, limits
		queue_item(OP_TIME, 16'hFFFF, 32'd0);
		queue_item(OP_TIME, 16'h0000, 32'hFFFF_FFFF);
		queue_item(OP_VEL, 16'h0000, 32'hFFFF_FFFF);
		queue_item(OP_VEL, 16'h7FFF, 32'd0);
		queue_item(OP_TIME, 16'h0000, 32'd7811);
		queue_item(OP_TIME, 16'h0000, 32'd7812);
		queue_item(OP_TIME, 16'h0000, 32'd40000);
		queue_item(OP_VEL, 16'h8000, 32'd0);
		queue_item(OP_TIME, 16'h0000, 32'd55624);
		queue_item(OP_VEL, 16'h0000, 32'd0);
		queue_item(OP_TIME, 16'h0000, 32'd60000);
		queue_item(OP_VEL, 16'd2560, 32'd0);
		queue_item(OP_VEL, 16'd2559, 32'd0);
		queue_item(OP_VEL, 16'hFFFF, 32'd0);
		queue_item(OP_VEL, 16'h0001, 32'd0);
		queue_item(OP_VEL, 16'h7FFF, 32'd0);
		queue_item(OP_TIME, 16'h0000, 32'hFFFF_FFFF);
		queue_item(OP_TIME, 16'h0000, 32'h0000_2000);
		sample_clock = 32'h0000_2000;

		configure_axis(32'd1, 32'd1, 32'hFFFF_FFFF, STALL_RX_HEAVY);
		queue_random(325, 32'd300, 1, 600);

		configure_axis(32'd50000, 32'd100, 32'd5000, STALL_RX_HEAVY);
		hold_req <= hold_req + 1;
		queue_random(325, 32'd6000, 2000, 32767);

		configure_axis(SCALE_RST, MIN_RST, MAX_RST, STALL_TX_HEAVY);
		queue_random(325, 32'd60000, 2560, 32767);

		// all registers at the top: interval of all ones, wrap of the mark
		configure_axis(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, STALL_TX_HEAVY);
		queue_item(OP_VEL, 16'h0100, 32'd0);
		wait_settled();
		m = axis_mark;
		queue_item(OP_TIME, 16'h0000, m - 32'd2);
		queue_item(OP_TIME, 16'h0000, m - 32'd1);
		queue_item(OP_TIME, 16'h0000, m - 32'd2);
		queue_item(OP_VEL, 16'h00FF, 32'd0);
		queue_item(OP_VEL, 16'hFF01, 32'd0);
		queue_random(100, 32'h8000_0000, 1, 32767);

		// zero scale: quotient clamps to the minimum, stopped when that is zero
		configure_axis(32'd0, 32'd0, 32'd1000, STALL_TX_HEAVY);
		queue_random(25, 32'd100, 1, 32767);
		configure_axis(32'd0, 32'd7, 32'd1000, STALL_TX_HEAVY);
		queue_random(75, 32'd40, 1, 32767);

		// minimum above maximum keeps the axis stopped
		configure_axis(32'd50000, 32'd1000, 32'd500, STALL_TX_HEAVY);
		queue_random(50, 32'd2000, 1, 32767);

		configure_axis(32'd1, 32'd1, 32'hFFFF_FFFF, STALL_NONE);
		queue_random(250, 32'd300, 1, 600);

		configure_axis(32'd300000, 32'd1, 32'd20000, STALL_NONE);
		queue_random(250, 32'd5000, 3840, 32767);

		wait_settled();
		repeat (END_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
